FILE: rtl/core/bba_pkg.sv
// bba_pkg: shared constants and types for the buddy block allocator.
// Depends on nothing; imported by every module under rtl/core.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int HeapPages   = 16;
  localparam int PageBytes   = 4096;
  localparam int MinBlock    = 8;
  localparam int HeaderBytes = 2;
  localparam int Slots       = HeapPages * (PageBytes / MinBlock);
  localparam int SlotW       = $clog2(Slots);
  localparam int LinkW       = SlotW + 1;
  localparam int TopLevel    = $clog2(PageBytes / MinBlock);
  localparam int Levels      = TopLevel + 1;
  localparam int LvW         = $clog2(Levels);
  localparam int PageSlotW   = $clog2(PageBytes / MinBlock);
  localparam int MinShift    = $clog2(MinBlock);
  localparam int PagesW      = $clog2(HeapPages + 1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
  localparam logic [1:0] REG_PAGE_LIMIT = 2'd0;

  // Link memory port (one read, one write per cycle)
  typedef struct packed {
    logic             re;
    logic [SlotW-1:0] raddr;
    logic             we;
    logic [SlotW-1:0] waddr;
    logic [LinkW-1:0] wdata;
  } link_req_t;

  // Level memory port
  typedef struct packed {
    logic             re;
    logic [SlotW-1:0] raddr;
    logic             we;
    logic [SlotW-1:0] waddr;
    logic [LvW-1:0]   wdata;
  } lvl_req_t;
endpackage

FILE: rtl/core/bba_link_mem.sv
// bba_link_mem: next-link store, one entry per minimum-size slot.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_link_mem import bba_pkg::*; (
  input  logic             clk,
  input  link_req_t        req,
  output logic [LinkW-1:0] rdata
);
  logic [LinkW-1:0] mem [Slots];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule

FILE: rtl/core/bba_level_mem.sv
// bba_level_mem: recorded level of each allocated block.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_level_mem import bba_pkg::*; (
  input  logic           clk,
  input  lvl_req_t       req,
  output logic [LvW-1:0] rdata
);
  logic [LvW-1:0] mem [Slots];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule

FILE: rtl/core/bba_ctrl.sv
// bba_ctrl: request sequencer; walks free lists held in the link memory.
// Depends on bba_pkg; drives bba_link_mem and bba_level_mem ports.
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [15:0]       req_size,
  input  logic [15:0]       payload_offset,
  input  logic [4:0]        page_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       result_offset,
  output logic              success,
  output link_req_t         lreq,
  input  logic [LinkW-1:0]  lrdata,
  output lvl_req_t          vreq,
  input  logic [LvW-1:0]    vrdata
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_POPW  = 9'b000000100,
    S_SPLIT = 9'b000001000,
    S_LVLW  = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_WALKW = 9'b001000000,
    S_PUSH  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [LinkW-1:0] heads [Levels];
  logic [PagesW-1:0] pages_used;
  logic [LvW-1:0] k, lv;
  logic [SlotW-1:0] slot;
  logic [LinkW-1:0] prev, cur;
  logic [SlotW:0] steps;
  logic is_alloc;

  logic [16:0] full;
  logic [LvW-1:0] k_calc;
  logic [15:0] off_m;
  logic [SlotW-1:0] buddy;
  logic [PagesW-1:0] limit;

  assign full = {1'b0, req_size} + 17'(HeaderBytes);
  assign off_m = payload_offset - 16'(HeaderBytes);
  assign buddy = slot ^ (SlotW'(1) << lv);
  assign limit = (32'(page_limit) < HeapPages) ? PagesW'(page_limit) : PagesW'(HeapPages);

  always_comb begin
    k_calc = LvW'(TopLevel);
    for (int j = TopLevel - 1; j >= 0; j--) begin
      if (17'(MinBlock << j) >= full) k_calc = LvW'(j);
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    lreq = '0;
    vreq = '0;
    case (state)
      S_IDLE: begin
        vreq.re = in_valid && in_ready && func == FUNC_FREE;
        vreq.raddr = off_m[MinShift +: SlotW];
      end
      S_SCAN: begin
        lreq.re = 1'b1;
        lreq.raddr = SlotW'(heads[lv] - LinkW'(1));
      end
      S_SPLIT: begin
        lreq.we = lv != k;
        lreq.waddr = slot ^ (SlotW'(1) << (lv - LvW'(1)));
        lreq.wdata = heads[lv - LvW'(1)];
        vreq.we = lv == k;
        vreq.waddr = slot;
        vreq.wdata = k;
      end
      S_WALK: begin
        lreq.re = 1'b1;
        lreq.raddr = SlotW'(cur - LinkW'(1));
      end
      S_WALKW: begin
        // unlink cur from prev when it is the buddy
        lreq.we = (cur == LinkW'(buddy) + LinkW'(1)) && prev != '0;
        lreq.waddr = SlotW'(prev - LinkW'(1));
        lreq.wdata = lrdata;
      end
      S_PUSH: begin
        lreq.we = 1'b1;
        lreq.waddr = slot;
        lreq.wdata = heads[lv];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pages_used <= '0;
      for (int j = 0; j < Levels; j++) heads[j] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          result_offset <= '0;
          success <= 1'b0;
          is_alloc <= func == FUNC_ALLOC;
          if (func == FUNC_ALLOC) begin
            if (req_size == '0 || full > 17'(PageBytes)) state <= S_OUT;
            else begin
              k <= k_calc; lv <= k_calc; state <= S_SCAN;
            end
          end else begin
            if (payload_offset == '0) state <= S_OUT;
            else begin
              slot <= off_m[MinShift +: SlotW];
              state <= S_LVLW;
            end
          end
        end
        S_SCAN: begin
          if (heads[lv] != '0) begin
            slot <= SlotW'(heads[lv] - LinkW'(1));
            state <= S_POPW;
          end else if (lv == LvW'(TopLevel)) begin
            if (pages_used >= limit) state <= S_OUT;
            else begin
              slot <= SlotW'(pages_used) << PageSlotW;
              pages_used <= pages_used + PagesW'(1);
              state <= S_SPLIT;
            end
          end else lv <= lv + LvW'(1);
        end
        S_POPW: begin
          heads[lv] <= lrdata;
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (lv != k) begin
            heads[lv - LvW'(1)] <= LinkW'(slot ^ (SlotW'(1) << (lv - LvW'(1)))) + LinkW'(1);
            lv <= lv - LvW'(1);
          end else begin
            result_offset <= 16'({slot, MinShift'(0)}) + 16'(HeaderBytes);
            success <= 1'b1;
            state <= S_OUT;
          end
        end
        S_LVLW: begin
          lv <= (vrdata > LvW'(TopLevel)) ? LvW'(TopLevel) : vrdata;
          prev <= '0;
          cur <= heads[(vrdata > LvW'(TopLevel)) ? LvW'(TopLevel) : vrdata];
          steps <= '0;
          state <= (vrdata >= LvW'(TopLevel)) ? S_PUSH : S_WALK;
        end
        S_WALK: begin
          if (cur == '0 || steps == (SlotW+1)'(Slots)) state <= S_PUSH;
          else state <= S_WALKW;
        end
        S_WALKW: begin
          if (cur == LinkW'(buddy) + LinkW'(1)) begin
            if (prev == '0) heads[lv] <= lrdata;
            slot <= slot & ~(SlotW'(1) << lv);
            lv <= lv + LvW'(1);
            prev <= '0;
            cur <= heads[lv + LvW'(1)];
            steps <= '0;
            state <= (lv + LvW'(1) == LvW'(TopLevel)) ? S_PUSH : S_WALK;
          end else begin
            prev <= cur;
            cur <= lrdata;
            steps <= steps + (SlotW+1)'(1);
            state <= S_WALK;
          end
        end
        S_PUSH: begin
          heads[lv] <= LinkW'(slot) + LinkW'(1);
          success <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pages: assert property (@(posedge clk) disable iff (rst)
    32'(pages_used) <= HeapPages) else $error("pages over heap size");
  a_fail_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !success |-> result_offset == '0) else $error("failed result carries offset");
  a_free_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_alloc |-> result_offset == '0) else $error("free returned offset");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
`endif
endmodule

FILE: rtl/core/buddy_block_allocator.sv
// buddy_block_allocator: top level; APB register, stream ports, memories.
// Depends on bba_pkg, bba_ctrl, bba_link_mem, bba_level_mem.
//   channel | dir | fields
//   s_axis  | in  | tuser: func[0]; tdata: req_size[15:0], payload_offset[31:16]
//   m_axis  | out | tdata: result_offset[15:0]; tuser: success[0]
//   apb     | cfg | page_limit at address 0
// Allocate: scan levels up, pop a free list or take a new page, split down;
// zero size or oversize ends at once, a full heap after the scan.
// Free: read the level, walk free lists merging with each buddy found, push.
// One item at a time; a held result blocks the next item until taken.
// Reset is synchronous; memories are not cleared and need no sweep.
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size, payload_offset
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_offset
  output logic        m_axis_tuser,   // success
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] page_limit;
  link_req_t lreq;
  lvl_req_t vreq;
  logic [LinkW-1:0] lrdata;
  logic [LvW-1:0] vrdata;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PAGE_LIMIT) ? {27'd0, page_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) page_limit <= 5'd16;
    else if (psel && penable && pwrite && paddr == REG_PAGE_LIMIT) page_limit <= pwdata[4:0];
  end

  bba_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tuser), .req_size(s_axis_tdata[15:0]),
    .payload_offset(s_axis_tdata[31:16]), .page_limit,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .result_offset(m_axis_tdata), .success(m_axis_tuser),
    .lreq, .lrdata, .vreq, .vrdata
  );
  bba_link_mem u_link (.clk, .req(lreq), .rdata(lrdata));
  bba_level_mem u_lvl (.clk, .req(vreq), .rdata(vrdata));
endmodule
